### design/assert_macros.svh
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising clock edge outside reset.
`define LFBM_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("%m: assertion failed");

// The expression must never be true at a rising clock edge outside reset.
`define LFBM_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    `LFBM_ASSERT(lbl, clk, rst_n, !(expr))

`endif

### design/lfbm_pkg.sv
`timescale 1ns / 1ps

package lfbm_pkg;

    // Pool geometry.
    localparam int BUFFER_COUNT = 4;
    localparam int FRAME_BYTES  = 153600;

    // Widths of internal state.
    localparam int BUF_W   = $clog2(BUFFER_COUNT);
    localparam int WIDX_W  = $clog2(BUFFER_COUNT + 1);
    localparam int BYTES_W = $clog2(FRAME_BYTES + 1);
    localparam int DROP_W  = $clog2(BUFFER_COUNT);
    localparam int GEN_W   = 32;

    // Widths of the ports.
    localparam int REQ_W     = 2;
    localparam int CHUNK_W   = 16;
    localparam int RELEASE_W = 8;
    localparam int LIMIT_W   = 8;
    localparam int OUT_BUF_W = 2;
    localparam int OFFSET_W  = 18;
    localparam int CNT_W     = 32;

    // Chunk offset plus length never overflows this width.
    localparam int SUM_W = ((BYTES_W > CHUNK_W) ? BYTES_W : CHUNK_W) + 1;

    localparam logic [LIMIT_W-1:0] ABORT_LIMIT_RESET = LIMIT_W'(10);
    localparam logic [LIMIT_W-1:0] CONSEC_MAX        = {LIMIT_W{1'b1}};

    typedef enum logic [1:0] {
        ST_FREE    = 2'd0,
        ST_WRITING = 2'd1,
        ST_READY   = 2'd2,
        ST_HELD    = 2'd3
    } t_buf_state;

    typedef enum logic [REQ_W-1:0] {
        REQ_CHUNK   = 2'd0,
        REQ_DEQUEUE = 2'd1,
        REQ_RELEASE = 2'd2,
        REQ_NONE    = 2'd3
    } t_req;

    // One input word as held in the input register.
    typedef struct packed {
        t_req                   req;
        logic                   chunk_ok;
        logic                   device_removed;
        logic [CHUNK_W-1:0]     chunk_bytes;
        logic                   last_chunk;
        logic                   stream_active;
        logic [RELEASE_W-1:0]   release_index;
    } t_item;

    // One result word as held in the result register.
    typedef struct packed {
        logic                   write_enable;
        logic [OUT_BUF_W-1:0]   write_buffer;
        logic [OFFSET_W-1:0]    write_offset;
        logic                   frame_published;
        logic                   dequeue_valid;
        logic [OUT_BUF_W-1:0]   dequeue_buffer;
        logic [CNT_W-1:0]       dropped_count;
        logic [CNT_W-1:0]       error_count;
        logic                   abort_request;
    } t_result;

endpackage

### design/latest_frame_buffer_manager.sv
`timescale 1ns / 1ps

// Channel   | Direction | Handshake                    | Word
// ----------+-----------+------------------------------+-------------------------------
// command   | in        | start high, busy low         | i_req_type .. i_release_index
// result    | out       | o_done strobe, one cycle     | o_write_enable .. o_abort_request
// config    | in        | i_cfg_valid and o_cfg_ready  | i_cfg_data (error abort limit)
//
// One command word is taken every cycle outside reset; its result word is registered
// in the input register and then in the result register, around one pass of
// the buffer-state update logic; the generation compare matrix sets that path.
// Reset is synchronous and active low; busy and not-ready are shown during reset.
// The result side cannot stall, so nothing ever holds the command side off.

module latest_frame_buffer_manager (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Command channel
    input  logic                               start,
    output logic                               busy,
    input  logic [lfbm_pkg::REQ_W-1:0]         i_req_type,
    input  logic                               i_chunk_ok,
    input  logic                               i_device_removed,
    input  logic [lfbm_pkg::CHUNK_W-1:0]       i_chunk_bytes,
    input  logic                               i_last_chunk,
    input  logic                               i_stream_active,
    input  logic [lfbm_pkg::RELEASE_W-1:0]     i_release_index,
    // Configuration channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [lfbm_pkg::LIMIT_W-1:0]       i_cfg_data,
    // Result channel
    output logic                               o_done,
    output logic                               o_write_enable,
    output logic [lfbm_pkg::OUT_BUF_W-1:0]     o_write_buffer,
    output logic [lfbm_pkg::OFFSET_W-1:0]      o_write_offset,
    output logic                               o_frame_published,
    output logic                               o_dequeue_valid,
    output logic [lfbm_pkg::OUT_BUF_W-1:0]     o_dequeue_buffer,
    output logic [lfbm_pkg::CNT_W-1:0]         o_dropped_count,
    output logic [lfbm_pkg::CNT_W-1:0]         o_error_count,
    output logic                               o_abort_request
);

    localparam int NB = lfbm_pkg::BUFFER_COUNT;
    localparam logic [lfbm_pkg::SUM_W-1:0]  FRAME_LIMIT = lfbm_pkg::SUM_W'(lfbm_pkg::FRAME_BYTES);
    localparam logic [lfbm_pkg::WIDX_W-1:0] NO_WRITER   = lfbm_pkg::WIDX_W'(NB);

    // Handshake and pipeline control
    logic                               accept;
    logic                               r_in_valid;
    logic                               r_out_valid;
    lfbm_pkg::t_item                    r_item;
    lfbm_pkg::t_result                  r_res;
    lfbm_pkg::t_result                  n_res;
    logic [lfbm_pkg::LIMIT_W-1:0]       r_limit;

    // Pool state
    lfbm_pkg::t_buf_state               r_status [NB];
    lfbm_pkg::t_buf_state               n_status [NB];
    logic [lfbm_pkg::GEN_W-1:0]         r_gen [NB];
    logic [lfbm_pkg::GEN_W-1:0]         n_gen [NB];
    logic [lfbm_pkg::GEN_W-1:0]         r_gen_ctr;
    logic [lfbm_pkg::GEN_W-1:0]         n_gen_ctr;
    logic [lfbm_pkg::WIDX_W-1:0]        r_writer;
    logic [lfbm_pkg::WIDX_W-1:0]        n_writer;
    logic [lfbm_pkg::BYTES_W-1:0]       r_bytes;
    logic [lfbm_pkg::BYTES_W-1:0]       n_bytes;
    logic                               r_discard;
    logic                               n_discard;
    logic [lfbm_pkg::LIMIT_W-1:0]       r_consec;
    logic [lfbm_pkg::LIMIT_W-1:0]       n_consec;
    logic [lfbm_pkg::CNT_W-1:0]         r_dropped;
    logic [lfbm_pkg::CNT_W-1:0]         n_dropped;
    logic [lfbm_pkg::CNT_W-1:0]         r_errors;
    logic [lfbm_pkg::CNT_W-1:0]         n_errors;

    // Working signals of the update pass
    logic                               has_writer;
    logic [lfbm_pkg::BUF_W-1:0]         writer_buf;
    logic [lfbm_pkg::SUM_W-1:0]         byte_sum;
    logic [lfbm_pkg::LIMIT_W-1:0]       consec_inc;
    logic [NB-1:0]                      ready;
    logic [NB-1:0]                      winner;
    logic                               any_ready;
    logic [lfbm_pkg::BUF_W-1:0]         best_idx;
    logic [lfbm_pkg::DROP_W-1:0]        drop_cnt;
    logic                               do_pick;
    logic                               pick_found;
    logic [lfbm_pkg::BUF_W-1:0]         pick_idx;
    logic [31:0]                        wbuf_ext;
    logic [31:0]                        dbuf_ext;

    // The block is never stalled by the result side; it only refuses during reset.
    assign busy        = ~i_rst_n;
    assign o_cfg_ready = i_rst_n;
    assign accept      = start & ~busy;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.req            <= lfbm_pkg::t_req'(i_req_type);
            r_item.chunk_ok       <= i_chunk_ok;
            r_item.device_removed <= i_device_removed;
            r_item.chunk_bytes    <= i_chunk_bytes;
            r_item.last_chunk     <= i_last_chunk;
            r_item.stream_active  <= i_stream_active;
            r_item.release_index  <= i_release_index;
        end
    end

    // Abort limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= lfbm_pkg::ABORT_LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_limit <= i_cfg_data;
        end
    end

    // Common terms of the current state.
    assign has_writer = (r_writer < NO_WRITER);
    assign writer_buf = r_writer[lfbm_pkg::BUF_W-1:0];
    assign byte_sum   = lfbm_pkg::SUM_W'(r_bytes) + lfbm_pkg::SUM_W'(r_item.chunk_bytes);
    assign consec_inc = (r_consec == lfbm_pkg::CONSEC_MAX) ? r_consec
                                                           : r_consec + lfbm_pkg::LIMIT_W'(1);

    // Newest ready buffer: pairwise generation compares, higher index wins a tie.
    always_comb begin
        for (int i = 0; i < NB; i++) begin
            ready[i] = (r_status[i] == lfbm_pkg::ST_READY);
        end
        for (int i = 0; i < NB; i++) begin
            winner[i] = ready[i];
            for (int j = 0; j < NB; j++) begin
                if (j > i && ready[j] && !(r_gen[i] > r_gen[j])) begin
                    winner[i] = 1'b0;
                end
                if (j < i && ready[j] && !(r_gen[i] >= r_gen[j])) begin
                    winner[i] = 1'b0;
                end
            end
        end
        any_ready = |ready;
        best_idx  = '0;
        drop_cnt  = '0;
        for (int i = 0; i < NB; i++) begin
            if (winner[i]) begin
                best_idx = lfbm_pkg::BUF_W'(i);
            end
            if (ready[i] && !winner[i]) begin
                drop_cnt = drop_cnt + lfbm_pkg::DROP_W'(1);
            end
        end
    end

    // One update pass per command word.
    always_comb begin
        n_status  = r_status;
        n_gen     = r_gen;
        n_gen_ctr = r_gen_ctr;
        n_writer  = r_writer;
        n_bytes   = r_bytes;
        n_discard = r_discard;
        n_consec  = r_consec;
        n_dropped = r_dropped;
        n_errors  = r_errors;
        n_res     = '0;
        do_pick   = 1'b0;
        wbuf_ext  = 32'(writer_buf);
        dbuf_ext  = 32'(best_idx);

        if (r_in_valid) begin
            case (r_item.req)
                lfbm_pkg::REQ_CHUNK: begin
                    if (!r_item.chunk_ok) begin
                        // Failed transfer: drop the frame in progress.
                        n_errors  = r_errors + lfbm_pkg::CNT_W'(1);
                        n_dropped = r_dropped + lfbm_pkg::CNT_W'(1);
                        n_consec  = consec_inc;
                        if (has_writer) begin
                            n_status[writer_buf] = lfbm_pkg::ST_FREE;
                        end
                        n_bytes   = '0;
                        n_discard = 1'b1;
                        n_res.abort_request = r_item.device_removed || (consec_inc >= r_limit);
                    end else begin
                        n_consec = '0;
                        if (!r_item.stream_active || r_discard || !has_writer) begin
                            // Chunk is thrown away; end of frame restarts the writer.
                            if (r_item.last_chunk) begin
                                n_dropped = r_dropped + lfbm_pkg::CNT_W'(1);
                                do_pick   = 1'b1;
                            end
                        end else if (byte_sum > FRAME_LIMIT) begin
                            // Frame overflow.
                            n_dropped            = r_dropped + lfbm_pkg::CNT_W'(1);
                            n_status[writer_buf] = lfbm_pkg::ST_FREE;
                            n_bytes              = '0;
                            n_discard            = 1'b1;
                        end else begin
                            n_res.write_enable = 1'b1;
                            n_res.write_buffer = wbuf_ext[lfbm_pkg::OUT_BUF_W-1:0];
                            n_res.write_offset = lfbm_pkg::OFFSET_W'(r_bytes);
                            n_bytes            = byte_sum[lfbm_pkg::BYTES_W-1:0];
                            if (r_item.last_chunk) begin
                                if (byte_sum == FRAME_LIMIT) begin
                                    n_gen_ctr             = r_gen_ctr + lfbm_pkg::GEN_W'(1);
                                    n_gen[writer_buf]     = r_gen_ctr + lfbm_pkg::GEN_W'(1);
                                    n_status[writer_buf]  = lfbm_pkg::ST_READY;
                                    n_res.frame_published = 1'b1;
                                end else begin
                                    // Short frame.
                                    n_status[writer_buf] = lfbm_pkg::ST_FREE;
                                    n_dropped            = r_dropped + lfbm_pkg::CNT_W'(1);
                                end
                                do_pick = 1'b1;
                            end
                        end
                    end
                end
                lfbm_pkg::REQ_DEQUEUE: begin
                    // Hold the newest ready frame and drop the older ones.
                    if (any_ready) begin
                        for (int i = 0; i < NB; i++) begin
                            if (ready[i] && !winner[i]) begin
                                n_status[i] = lfbm_pkg::ST_FREE;
                            end
                        end
                        n_dropped            = r_dropped + lfbm_pkg::CNT_W'(drop_cnt);
                        n_status[best_idx]   = lfbm_pkg::ST_HELD;
                        n_res.dequeue_valid  = 1'b1;
                        n_res.dequeue_buffer = dbuf_ext[lfbm_pkg::OUT_BUF_W-1:0];
                    end
                end
                lfbm_pkg::REQ_RELEASE: begin
                    // Out-of-range indexes match no buffer and are ignored.
                    for (int i = 0; i < NB; i++) begin
                        if (r_item.release_index == lfbm_pkg::RELEASE_W'(i) &&
                            r_status[i] == lfbm_pkg::ST_HELD) begin
                            n_status[i] = lfbm_pkg::ST_FREE;
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        // Next writer is the lowest free buffer after this word's changes.
        pick_found = 1'b0;
        pick_idx   = '0;
        for (int i = 0; i < NB; i++) begin
            if (!pick_found && n_status[i] == lfbm_pkg::ST_FREE) begin
                pick_found = 1'b1;
                pick_idx   = lfbm_pkg::BUF_W'(i);
            end
        end
        if (do_pick) begin
            n_writer  = pick_found ? lfbm_pkg::WIDX_W'(pick_idx) : NO_WRITER;
            n_bytes   = '0;
            n_discard = !pick_found;
            if (pick_found) begin
                n_status[pick_idx] = lfbm_pkg::ST_WRITING;
            end
        end

        n_res.dropped_count = n_dropped;
        n_res.error_count   = n_errors;
    end

    // Pool state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NB; i++) begin
                r_status[i] <= lfbm_pkg::ST_FREE;
                r_gen[i]    <= '0;
            end
            r_status[0] <= lfbm_pkg::ST_WRITING;
            r_gen_ctr   <= '0;
            r_writer    <= '0;
            r_bytes     <= '0;
            r_discard   <= 1'b0;
            r_consec    <= '0;
            r_dropped   <= '0;
            r_errors    <= '0;
        end else begin
            r_status  <= n_status;
            r_gen     <= n_gen;
            r_gen_ctr <= n_gen_ctr;
            r_writer  <= n_writer;
            r_bytes   <= n_bytes;
            r_discard <= n_discard;
            r_consec  <= n_consec;
            r_dropped <= n_dropped;
            r_errors  <= n_errors;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid) begin
            r_res <= n_res;
        end
    end

    assign o_done            = r_out_valid;
    assign o_write_enable    = r_res.write_enable;
    assign o_write_buffer    = r_res.write_buffer;
    assign o_write_offset    = r_res.write_offset;
    assign o_frame_published = r_res.frame_published;
    assign o_dequeue_valid   = r_res.dequeue_valid;
    assign o_dequeue_buffer  = r_res.dequeue_buffer;
    assign o_dropped_count   = r_res.dropped_count;
    assign o_error_count     = r_res.error_count;
    assign o_abort_request   = r_res.abort_request;

endmodule

### design/lfbm_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lfbm_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    input  logic                               busy,
    input  logic                               o_done,
    input  logic                               o_write_enable,
    input  logic                               o_frame_published,
    input  logic                               o_dequeue_valid,
    input  logic [lfbm_pkg::CNT_W-1:0]         o_error_count
);

    // Every accepted word yields its result through the input and result registers.
    `LFBM_ASSERT(a_result_follows, i_clk, i_rst_n, (start && !busy) |-> ##2 o_done)

    // No result word appears without a matching accepted word.
    `LFBM_ASSERT(a_no_spurious_result, i_clk, i_rst_n, o_done |-> $past(start && !busy && i_rst_n, 2))

    // A word is either a chunk write or a dequeue, never both.
    `LFBM_ASSERT_NEVER(a_write_xor_dequeue, i_clk, i_rst_n, o_done && o_write_enable && o_dequeue_valid)

    // A published frame always comes with the write of its last chunk.
    `LFBM_ASSERT(a_publish_has_write, i_clk, i_rst_n, (o_done && o_frame_published) |-> o_write_enable)

    // Back-to-back results advance the error count by at most one.
    `LFBM_ASSERT(a_error_step, i_clk, i_rst_n, (o_done && $past(o_done)) |-> ((o_error_count - $past(o_error_count)) <= lfbm_pkg::CNT_W'(1)))

endmodule

bind latest_frame_buffer_manager lfbm_checker u_lfbm_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .start             (start),
    .busy              (busy),
    .o_done            (o_done),
    .o_write_enable    (o_write_enable),
    .o_frame_published (o_frame_published),
    .o_dequeue_valid   (o_dequeue_valid),
    .o_error_count     (o_error_count)
);
